// File: src/rgb_to_hsv_converter_core_defines.svh
// Assertion macros used by the checker file of the RGB to HSV converter.
`ifndef RGB_TO_HSV_CONVERTER_CORE_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_CORE_DEFINES_SVH

// Concurrent assertion clocked on clk, off while rst_n is low.
`define RHC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication built on the macro above.
`define RHC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    `RHC_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

// File: src/rhc_pkg.sv
// Types and constants shared by the RGB to HSV converter modules.
package rhc_pkg;

    localparam int CHAN_W   = 8;
    localparam int HUE_W    = 15;
    localparam int SAT_W    = 17;
    localparam int NUM_W    = 11;   // hue numerator, up to six deltas
    localparam int DIV_NW   = 24;   // dividend width of both dividers
    localparam int DIV_DW   = 8;    // divisor width
    localparam int DIV_QW   = 17;   // quotient bits, one per stage
    localparam int SAT_FRAC = 16;

    localparam logic [11:0] DEG60_Q6 = 12'd3840;   // 60 degrees in Q9.6

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [SAT_W-1:0]  saturation;
        logic [CHAN_W-1:0] value;
    } t_hsv;

    // classified pixel handed from front to back
    typedef struct packed {
        logic [CHAN_W-1:0] value;
        logic [CHAN_W-1:0] delta;
        logic [NUM_W-1:0]  num;
        logic              max_zero;
        logic              grey;
    } t_class;

endpackage

// File: src/rhc_front.sv
// Front end: accepts a pixel, finds max/min and the hue numerator, registers the word.
module rhc_front import rhc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_pixel i_pixel,
    output logic   o_valid,
    input  logic   i_ready,
    output t_class o_word
);

    logic [CHAN_W-1:0] w_hi, w_lo, w_d, w_x, w_y;
    logic [NUM_W-1:0]  w_base;
    logic              w_red_max, w_green_max;
    t_class            n_word;
    logic              r_valid;
    t_class            r_word;

    always_comb begin
        w_hi = i_pixel.red;
        if (i_pixel.green > w_hi) w_hi = i_pixel.green;
        if (i_pixel.blue > w_hi)  w_hi = i_pixel.blue;
        w_lo = i_pixel.red;
        if (i_pixel.green < w_lo) w_lo = i_pixel.green;
        if (i_pixel.blue < w_lo)  w_lo = i_pixel.blue;
        w_d = w_hi - w_lo;

        // ties: red over green, green over blue
        w_red_max   = (w_hi == i_pixel.red);
        w_green_max = !w_red_max && (w_hi == i_pixel.green);

        if (w_red_max) begin
            w_x    = i_pixel.green;
            w_y    = i_pixel.blue;
            // negative difference wraps by a full turn of six deltas
            w_base = (i_pixel.green < i_pixel.blue) ?
                     (NUM_W'(w_d) << 2) + (NUM_W'(w_d) << 1) : '0;
        end else if (w_green_max) begin
            w_x    = i_pixel.blue;
            w_y    = i_pixel.red;
            w_base = NUM_W'(w_d) << 1;
        end else begin
            w_x    = i_pixel.red;
            w_y    = i_pixel.green;
            w_base = NUM_W'(w_d) << 2;
        end

        n_word.value    = w_hi;
        n_word.delta    = w_d;
        n_word.num      = w_base + NUM_W'(w_x) - NUM_W'(w_y);
        n_word.max_zero = (w_hi == '0);
        n_word.grey     = (w_d == '0);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

endmodule

// File: src/rhc_queue.sv
// Short FIFO of classified words between the front and back ends.
module rhc_queue import rhc_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_class i_word,
    output logic   o_valid,
    input  logic   i_ready,
    output t_class o_word
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_class          r_mem [0:DEPTH-1];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_push, w_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

endmodule

// File: src/rhc_div.sv
// Pipelined restoring divider, one quotient bit per stage; dividend < divisor * 2^QW.
module rhc_div import rhc_pkg::*; #(
    parameter int NW = DIV_NW,
    parameter int DW = DIV_DW,
    parameter int QW = DIV_QW
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic [QW-1:0] o_quotient
);

    logic [DW-1:0] r_rem  [0:QW-1];
    logic [DW-1:0] r_div  [0:QW-1];
    logic [QW-1:0] r_low  [0:QW];
    logic [DW:0]   w_trial [0:QW-1];
    logic [DW-1:0] n_rem  [0:QW-1];
    logic          w_take [0:QW-1];

    // low word shifts out dividend bits and shifts in quotient bits
    always_comb begin
        for (int k = 0; k < QW; k++) begin
            w_trial[k] = {r_rem[k], r_low[k][QW-1]};
            w_take[k]  = (w_trial[k] >= {1'b0, r_div[k]});
            n_rem[k]   = w_take[k] ? DW'(w_trial[k] - {1'b0, r_div[k]}) : w_trial[k][DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DW'(i_dividend[NW-1:QW]);
            r_low[0] <= i_dividend[QW-1:0];
            r_div[0] <= i_divisor;
            for (int k = 0; k < QW; k++) begin
                r_low[k+1] <= {r_low[k][QW-2:0], w_take[k]};
                if (k < QW - 1) begin
                    r_rem[k+1] <= n_rem[k];
                    r_div[k+1] <= r_div[k];
                end
            end
        end
    end

    assign o_quotient = r_low[QW];

endmodule

// File: src/rhc_back.sv
// Back end: saturation and hue division pipelines and the output register.
module rhc_back import rhc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_class i_word,
    output logic   o_valid,
    input  logic   i_ready,
    output t_hsv   o_hsv
);

    localparam int STAGES = DIV_QW + 1;

    typedef struct packed {
        logic [CHAN_W-1:0] value;
        logic              max_zero;
        logic              grey;
    } t_side;

    logic              w_en;
    logic [DIV_NW-1:0] w_sat_dividend, w_hue_dividend;
    logic [DIV_QW-1:0] w_sat_q, w_hue_q;
    logic              r_vld  [0:STAGES-1];
    t_side             r_side [0:STAGES-1];
    logic              r_out_valid;
    t_hsv              r_out;
    t_side             w_last;

    // whole back pipe moves whenever the output register can take a word
    assign w_en    = !r_out_valid || i_ready;
    assign o_ready = w_en;

    assign w_sat_dividend = {i_word.delta, SAT_FRAC'(0)};
    assign w_hue_dividend = DIV_NW'(i_word.num) * DIV_NW'(DEG60_Q6);

    rhc_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_sat_div (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_dividend (w_sat_dividend),
        .i_divisor  (i_word.value),
        .o_quotient (w_sat_q)
    );

    rhc_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_hue_div (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_dividend (w_hue_dividend),
        .i_divisor  (i_word.delta),
        .o_quotient (w_hue_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < STAGES; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_valid <= r_vld[STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= '{value: i_word.value, max_zero: i_word.max_zero,
                           grey: i_word.grey};
            for (int k = 1; k < STAGES; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign w_last = r_side[STAGES-1];

    // black and grey pixels have a zero divisor; force those fields to zero
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.value      <= w_last.value;
            r_out.saturation <= w_last.max_zero ? '0 : w_sat_q;
            r_out.hue        <= w_last.grey ? '0 : w_hue_q[HUE_W-1:0];
        end
    end

    assign o_valid = r_out_valid;
    assign o_hsv   = r_out;

endmodule

// File: src/rgb_to_hsv_converter_core.sv
// RGB to HSV converter: takes one 8-bit RGB pixel per word and returns hue (Q9.6
// degrees), saturation (Q1.16) and value (max channel byte). It sustains one pixel
// per clock while the output is not stalled. The front end classifies each pixel
// into max, delta and a hue numerator and registers the result; a QUEUE_DEPTH-entry
// FIFO decouples it from the back end, where saturation and hue each go through a
// 17-stage restoring divider, one quotient bit per stage, followed by an output
// register. With no stalls a pixel passes through the front register, the FIFO,
// the divider input stage, the 17 divide stages and the output register. A stalled
// output freezes the back end while the FIFO keeps taking pixels until it fills.
module rgb_to_hsv_converter_core import rhc_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_pixel i_pixel,
    output logic   o_valid,
    input  logic   i_ready,
    output t_hsv   o_hsv
);

    logic   w_f_valid, w_f_ready;
    t_class w_f_word;
    logic   w_q_valid, w_q_ready;
    t_class w_q_word;

    rhc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pixel (i_pixel),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_word  (w_f_word)
    );

    rhc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_word  (w_f_word),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_word  (w_q_word)
    );

    rhc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_ready (w_q_ready),
        .i_word  (w_q_word),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_hsv   (o_hsv)
    );

endmodule

// File: src/rhc_checker.sv
// Port-level assertions for the RGB to HSV converter, bound to the top level.
`include "rgb_to_hsv_converter_core_defines.svh"

module rhc_checker import rhc_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_ready,
    input t_hsv o_hsv
);

    `RHC_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_hsv), "output word changed while stalled")
    `RHC_ASSERT_IMP(a_range, i_clk, i_rst_n, o_valid, (o_hsv.saturation <= 17'd65536) && (o_hsv.hue <= 15'd23039), "hue or saturation out of range")
    `RHC_ASSERT_IMP(a_black, i_clk, i_rst_n, o_valid && (o_hsv.value == 8'd0), (o_hsv.saturation == '0) && (o_hsv.hue == '0), "black pixel with nonzero hue or saturation")
    `RHC_ASSERT_IMP(a_grey, i_clk, i_rst_n, o_valid && (o_hsv.saturation == '0), o_hsv.hue == '0, "zero saturation with nonzero hue")

endmodule

bind rgb_to_hsv_converter_core rhc_checker u_checker (.*);

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the RGB to HSV converter: directed and random pixels checked against table values or a local model.
module tb_top;
    import rhc_pkg::*;

    localparam int HUE_DEG60 = 3840;    // 60 degrees in Q9.6
    localparam int N_DIR     = 22;
    localparam int N_RANDOM  = 1930;
    localparam int N_DRAIN   = 40;      // idle wait after the last expected result

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_ready;
    t_pixel i_pixel;
    logic   o_valid;
    logic   i_ready;
    t_hsv   o_hsv;

    t_hsv hsv_due[$];
    int   n_errors  = 0;
    int   n_results = 0;

    // red, green, blue, known, hue, saturation, value
    int dir_tab [N_DIR][7] = '{
        '{  0,   0,   0, 1,     0,     0,   0},
        '{255, 255, 255, 1,     0,     0, 255},
        '{128, 128, 128, 1,     0,     0, 128},
        '{  1,   1,   1, 1,     0,     0,   1},
        '{255,   0,   0, 1,     0, 65536, 255},
        '{  0, 255,   0, 1,  7680, 65536, 255},
        '{  0,   0, 255, 1, 15360, 65536, 255},
        '{255, 255,   0, 0,     0,     0,   0},
        '{  0, 255, 255, 0,     0,     0,   0},
        '{255,   0, 255, 0,     0,     0,   0},
        '{200,  10,  50, 0,     0,     0,   0},
        '{255,   0,   1, 0,     0,     0,   0},
        '{  1,   0,   0, 1,     0, 65536,   1},
        '{  0,   1,   0, 1,  7680, 65536,   1},
        '{  0,   0,   1, 1, 15360, 65536,   1},
        '{255, 254,   0, 0,     0,     0,   0},
        '{254, 255, 253, 0,     0,     0,   0},
        '{253, 254, 255, 0,     0,     0,   0},
        '{170,  85, 170, 0,     0,     0,   0},
        '{ 85, 170,  85, 0,     0,     0,   0},
        '{ 10, 200,  30, 0,     0,     0,   0},
        '{ 40,  20, 230, 0,     0,     0,   0}
    };

    rgb_to_hsv_converter_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pixel (i_pixel),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_hsv   (o_hsv)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_hsv hsv_of(t_pixel p);
        int   r, g, b, hi, lo, d, num;
        t_hsv res;
        r = p.red;
        g = p.green;
        b = p.blue;
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        d = hi - lo;
        num = 0;
        // ties resolve red first, then green
        if (d != 0) begin
            if (hi == r) begin
                num = g - b;
                if (num < 0) num += 6 * d;
            end else if (hi == g) begin
                num = 2 * d + b - r;
            end else begin
                num = 4 * d + r - g;
            end
        end
        res.value      = hi[7:0];
        res.saturation = (hi != 0) ? 17'((d << 16) / hi) : '0;
        res.hue        = (d != 0) ? 15'(num * HUE_DEG60 / d) : '0;
        return res;
    endfunction

    function automatic t_pixel rand_pixel();
        t_pixel     p;
        logic [7:0] a, c;
        int         mode;
        mode = $urandom_range(0, 9);
        p = 24'($urandom);
        a = 8'($urandom);
        c = 8'($urandom_range(0, a));
        case (mode)
            6: begin
                p = '{a, a, a};
            end
            7: begin
                case ($urandom_range(0, 2))
                    0: p = '{a, a, c};
                    1: p = '{a, c, a};
                    default: p = '{c, a, a};
                endcase
            end
            8: begin
                // channels at 0, 1, 254 or 255
                for (int k = 0; k < 3; k++)
                    p[k*8 +: 8] = ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                  ^ 8'($urandom_range(0, 1));
            end
            9: begin
                p[8*$urandom_range(0, 2) +: 8] = 8'h00;
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic send_pixel(input t_pixel pix, input t_hsv due, input bit fast);
        int gap;
        gap = fast ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= pix;
        do @(posedge i_clk); while (!o_ready);
        hsv_due.push_back(due);
    endtask

    initial begin
        t_pixel pix;
        t_hsv   due;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_pixel = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++) begin
            pix = '{8'(dir_tab[i][0]), 8'(dir_tab[i][1]), 8'(dir_tab[i][2])};
            if (dir_tab[i][3] != 0)
                due = '{15'(dir_tab[i][4]), 17'(dir_tab[i][5]), 8'(dir_tab[i][6])};
            else
                due = hsv_of(pix);
            send_pixel(pix, due, 1'b0);
        end

        // every other block of 150 words goes back to back
        for (int i = 0; i < N_RANDOM; i++) begin
            pix = rand_pixel();
            send_pixel(pix, hsv_of(pix), ((i / 150) % 2) == 1);
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (hsv_due.size() != 0) @(posedge i_clk);
        repeat (N_DRAIN) @(posedge i_clk);
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // result side: random stalls, two long hold-offs to back up the FIFO
    initial begin
        int   stall;
        t_hsv due;
        wait (i_rst_n);
        forever begin
            if (n_results == 400 || n_results == 1300)
                stall = 150;
            else if (((n_results / 170) % 3) == 1)
                stall = 0;
            else
                stall = $urandom_range(0, 10);
            @(negedge i_clk);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            n_results++;
            if (hsv_due.size() == 0) begin
                $error("unexpected word: hue %0d saturation %0d value %0d",
                       o_hsv.hue, o_hsv.saturation, o_hsv.value);
                n_errors++;
            end else begin
                due = hsv_due.pop_front();
                if (o_hsv.hue !== due.hue) begin
                    $error("hue: expected %0d, got %0d", due.hue, o_hsv.hue);
                    n_errors++;
                end
                if (o_hsv.saturation !== due.saturation) begin
                    $error("saturation: expected %0d, got %0d",
                           due.saturation, o_hsv.saturation);
                    n_errors++;
                end
                if (o_hsv.value !== due.value) begin
                    $error("value: expected %0d, got %0d", due.value, o_hsv.value);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        #1000000;
        $display("FAILURE");
        $finish;
    end

endmodule
